// ----- rtl/fisr_pkg.sv -----
// Package for the fast inverse square root pipeline.
// Holds the constants and the single-precision multiply and add functions.
// No dependencies.
`default_nettype none

package fisr_pkg;

   localparam logic [31:0] RSQRT_MAGIC = 32'h5f3759df;
   localparam logic [31:0] CANON_NAN   = 32'h7FC00000;
   localparam logic [31:0] FP_HALF     = 32'h3F000000;
   localparam logic [31:0] FP_ONE_HALF = 32'h3FC00000;
   localparam logic [7:0]  EXP_MAX     = 8'hFF;

   // Single-precision multiply, round to nearest even, subnormals included.
   // Any NaN result is returned as the canonical quiet NaN.
   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        sr;
      logic [7:0]  ea, eb, ea_e, eb_e;
      logic [22:0] fa, fb;
      logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
      logic [47:0] prod, pn, sh;
      logic [5:0]  lead;
      logic signed [10:0] be;
      logic [9:0]  be_eff, rs, bx;
      logic        lost, g, st;
      logic [23:0] mant;
      logic [24:0] mr;
      logic [32:0] w;
      logic [31:0] res;
      sr = a[31] ^ b[31];
      ea = a[30:23];
      eb = b[30:23];
      fa = a[22:0];
      fb = b[22:0];
      nan_a  = (ea == EXP_MAX) && (fa != '0);
      nan_b  = (eb == EXP_MAX) && (fb != '0);
      inf_a  = (ea == EXP_MAX) && (fa == '0);
      inf_b  = (eb == EXP_MAX) && (fb == '0);
      zero_a = (ea == '0) && (fa == '0);
      zero_b = (eb == '0) && (fb == '0);
      ea_e = (ea == '0) ? 8'd1 : ea;
      eb_e = (eb == '0) ? 8'd1 : eb;
      prod = {(ea != '0), fa} * {(eb != '0), fb};
      lead = '0;
      for (int i = 0; i < 48; i++) begin
         if (prod[i]) lead = 6'(i);
      end
      pn = prod << (6'd47 - lead);
      be = $signed({3'b0, ea_e}) + $signed({3'b0, eb_e}) - 11'sd173
           + $signed({5'b0, lead});
      if (be < 11'sd1) begin
         rs     = 10'(11'sd1 - be);
         be_eff = 10'd1;
      end else begin
         rs     = '0;
         be_eff = 10'(be);
      end
      if (rs >= 10'd48) begin
         sh   = '0;
         lost = |pn;
      end else begin
         sh   = pn >> rs;
         lost = |(pn & ((48'd1 << rs) - 48'd1));
      end
      mant = sh[47:24];
      g    = sh[23];
      st   = (|sh[22:0]) | lost;
      mr   = {1'b0, mant} + 25'(g & (st | mant[0]));
      bx   = be_eff - 10'd1;
      w    = {bx, 23'b0} + 33'(mr);
      if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
         res = CANON_NAN;
      end else if (inf_a || inf_b) begin
         res = {sr, EXP_MAX, 23'b0};
      end else if (zero_a || zero_b) begin
         res = {sr, 31'b0};
      end else if (w[32:23] >= 10'd255) begin
         res = {sr, EXP_MAX, 23'b0};
      end else begin
         res = {sr, w[30:0]};
      end
      return res;
   endfunction

   // Single-precision add, round to nearest even, subnormals included.
   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] big, sml, res;
      logic [7:0]  ea, eb, eg, es, d;
      logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sub;
      logic [26:0] a27, s27, bs;
      logic [27:0] sum;
      logic [4:0]  lead, lsh;
      logic [26:0] n27;
      logic [9:0]  be, bx;
      logic        g, st;
      logic [23:0] mant;
      logic [24:0] mr;
      logic [32:0] w;
      ea = a[30:23];
      eb = b[30:23];
      nan_a  = (ea == EXP_MAX) && (a[22:0] != '0);
      nan_b  = (eb == EXP_MAX) && (b[22:0] != '0);
      inf_a  = (ea == EXP_MAX) && (a[22:0] == '0);
      inf_b  = (eb == EXP_MAX) && (b[22:0] == '0);
      zero_a = (a[30:0] == '0);
      zero_b = (b[30:0] == '0);
      // Order the operands by magnitude.
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      eg = (big[30:23] == '0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
      d  = eg - es;
      a27 = {(big[30:23] != '0), big[22:0], 3'b0};
      s27 = {(sml[30:23] != '0), sml[22:0], 3'b0};
      if (d >= 8'd27) begin
         bs = 27'd1;
      end else begin
         bs = (s27 >> d) | 27'((s27 & ((27'd1 << d) - 27'd1)) != '0);
      end
      sub = big[31] ^ sml[31];
      sum = sub ? ({1'b0, a27} - {1'b0, bs}) : ({1'b0, a27} + {1'b0, bs});
      lead = '0;
      for (int i = 0; i < 28; i++) begin
         if (sum[i]) lead = 5'(i);
      end
      // Normalize, stopping at the subnormal boundary.
      lsh = '0;
      if (lead == 5'd27) begin
         n27 = {sum[27:2], sum[1] | sum[0]};
         be  = {2'b0, eg} + 10'd1;
      end else begin
         lsh = 5'd26 - lead;
         if ({3'b0, lsh} <= eg - 8'd1) begin
            n27 = sum[26:0] << lsh;
            be  = {2'b0, eg} - {5'b0, lsh};
         end else begin
            n27 = sum[26:0] << (eg - 8'd1);
            be  = 10'd1;
         end
      end
      mant = n27[26:3];
      g    = n27[2];
      st   = |n27[1:0];
      mr   = {1'b0, mant} + 25'(g & (st | mant[0]));
      bx   = be - 10'd1;
      w    = {bx, 23'b0} + 33'(mr);
      if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
         res = CANON_NAN;
      end else if (inf_a) begin
         res = a;
      end else if (inf_b) begin
         res = b;
      end else if (zero_a && zero_b) begin
         res = {a[31] & b[31], 31'b0};
      end else if (zero_b) begin
         res = a;
      end else if (zero_a) begin
         res = b;
      end else if (sum == '0) begin
         res = '0;
      end else if (w[32:23] >= 10'd255) begin
         res = {big[31], EXP_MAX, 23'b0};
      end else begin
         res = {big[31], w[30:0]};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/fisr_if.sv -----
// Valid/ready stream interfaces for the operand and result words.
// Uses no package.
`default_nettype none

interface fisr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value_bits;
   modport source (output valid, output value_bits, input ready);
   modport sink   (input valid, input value_bits, output ready);
endinterface

interface fisr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] inv_sqrt_bits;
   modport source (output valid, output inv_sqrt_bits, input ready);
   modport sink   (input valid, input inv_sqrt_bits, output ready);
endinterface

`default_nettype wire

// ----- rtl/fast_inverse_sqrt_top.sv -----
// Fast inverse square root pipeline, top level.
// Depends on fisr_pkg and the stream interfaces in fisr_if.sv.
`default_nettype none

// Takes one single-precision word per cycle and returns the bit-trick
// estimate of 1/sqrt(x) refined by one Newton step, each float operation
// rounded to nearest even; NaN results come out as 0x7FC00000. There is one
// stage for each floating-point operation (halving, two multiplies, the
// subtract from 1.5 and the final multiply). Throughput is one word per
// cycle; when the result word is not taken, the whole pipeline holds and
// the input is not ready.
module fast_inverse_sqrt_top
   import fisr_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   fisr_req_if.sink    req_if,
   fisr_rsp_if.source  rsp_if
);

   logic        en;
   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic        v1_in, v2_in, v3_in, v4_in, v5_in;
   logic [31:0] x2_ff, y1_ff, p2_ff, y2_ff, t3_ff, y3_ff, d4_ff, y4_ff, r5_ff;
   logic [31:0] x2_in, y1_in, p2_in, t3_in, d4_in, r_raw, r5_in;

   // The pipeline advances whenever the output register is free or drained.
   assign en           = !v5_ff || rsp_if.ready;
   assign req_if.ready = en;

   // One floating-point operation per stage.
   always_comb begin
      v1_in = req_if.valid;
      v2_in = v1_ff;
      v3_in = v2_ff;
      v4_in = v3_ff;
      v5_in = v4_ff;
      x2_in = fp_mul(req_if.value_bits, FP_HALF);
      y1_in = RSQRT_MAGIC - {req_if.value_bits[31], req_if.value_bits[31:1]};
      p2_in = fp_mul(x2_ff, y1_ff);
      t3_in = fp_mul(p2_ff, y2_ff);
      d4_in = fp_add(FP_ONE_HALF, {~t3_ff[31], t3_ff[30:0]});
      r_raw = fp_mul(y4_ff, d4_ff);
      r5_in = ((r_raw[30:23] == EXP_MAX) && (r_raw[22:0] != '0)) ? CANON_NAN : r_raw;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // Data registers; the guess travels alongside the partial results.
   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         p2_ff <= p2_in;
         y2_ff <= y1_ff;
         t3_ff <= t3_in;
         y3_ff <= y2_ff;
         d4_ff <= d4_in;
         y4_ff <= y3_ff;
         r5_ff <= r5_in;
      end
   end

   assign rsp_if.valid         = v5_ff;
   assign rsp_if.inv_sqrt_bits = r5_ff;

   // A stalled output freezes the inner stages too.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && !rsp_if.ready) |=> ($stable(p2_ff) && $stable(v2_ff)))
      else $error("pipeline moved during an output stall");

   // Any NaN that leaves is the canonical one.
   a_nan_canon: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && (r5_ff[30:23] == EXP_MAX) && (r5_ff[22:0] != '0)) |->
      (r5_ff == CANON_NAN))
      else $error("non-canonical NaN on output");

   // An accepted word occupies the first stage next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> v1_ff)
      else $error("accepted word lost at first stage");

endmodule

`default_nettype wire

// ----- dv/fast_inverse_sqrt_top_tb.sv -----
// Testbench for fast_inverse_sqrt_top: directed and random operand words,
// each checked against a single-precision model built on double arithmetic.
// Depends on fisr_pkg, the stream interfaces in fisr_if.sv and the top level.
`default_nettype none

module fast_inverse_sqrt_top_tb;
   import fisr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   fisr_req_if req_if ();
   fisr_rsp_if rsp_if ();

   fast_inverse_sqrt_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   logic [31:0] expected_words[$];
   int          error_count;
   int          stall_mode;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Widens a single-precision pattern to a real, exactly.
   function automatic real f32_to_real(input logic [31:0] b);
      real v;
      if (b[30:23] == EXP_MAX) begin
         v = $bitstoreal({b[31], 11'h7FF, b[22:0], 29'b0});
      end else if (b[30:23] == 8'd0) begin
         v = real'(b[22:0]) * (2.0 ** (-149));
         if (b[31]) v = -v;
      end else begin
         v = $bitstoreal({b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'b0});
      end
      return v;
   endfunction

   // Rounds a real to single precision, nearest even, subnormals included.
   function automatic logic [31:0] real_to_f32(input real v);
      logic [63:0] d, m, q, rem, half;
      int          e, sh;
      logic [31:0] res;
      d = $realtobits(v);
      e = int'(d[62:52]) - 1023;
      if (d[62:52] == 11'h7FF) begin
         res = (d[51:0] != '0) ? CANON_NAN : {d[63], EXP_MAX, 23'b0};
      end else if (d[62:52] == 11'd0 || e < -160) begin
         res = {d[63], 31'b0};
      end else if (e > 127) begin
         res = {d[63], EXP_MAX, 23'b0};
      end else begin
         m  = {11'b1, d[51:0]};
         sh = (e >= -126) ? 29 : 29 + (-126 - e);
         q    = m >> sh;
         rem  = m & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) q = q + 64'd1;
         // q carries the hidden bit, so adding it lets a carry bump the exponent.
         if (e >= -126) q = q + (64'(e + 126) << 23);
         if (q[31:23] >= 9'd255) res = {d[63], EXP_MAX, 23'b0};
         else res = {d[63], q[30:0]};
      end
      return res;
   endfunction

   // Predicts the result word: bit-trick guess and one Newton step.
   function automatic logic [31:0] predict_inv_sqrt(input logic [31:0] xb);
      logic [31:0] half_x, guess, prod, tsq, diff, r;
      half_x = real_to_f32(f32_to_real(xb) * 0.5);
      guess  = RSQRT_MAGIC - {xb[31], xb[31:1]};
      prod   = real_to_f32(f32_to_real(half_x) * f32_to_real(guess));
      tsq    = real_to_f32(f32_to_real(prod) * f32_to_real(guess));
      diff   = real_to_f32(1.5 - f32_to_real(tsq));
      r      = real_to_f32(f32_to_real(guess) * f32_to_real(diff));
      if (r[30:23] == EXP_MAX && r[22:0] != '0) r = CANON_NAN;
      return r;
   endfunction

   // Records each accepted operand word and checks each accepted result word.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         expected_words.push_back(predict_inv_sqrt(req_if.value_bits));
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word %h", rsp_if.inv_sqrt_bits);
            error_count++;
         end else if (expected_words[0] !== rsp_if.inv_sqrt_bits) begin
            $error("inv_sqrt_bits: expected %h actual %h",
                   expected_words[0], rsp_if.inv_sqrt_bits);
            error_count++;
            void'(expected_words.pop_front());
         end else begin
            void'(expected_words.pop_front());
         end
      end
   end

   // Result-side stalls in one of four randomly chosen modes.
   initial begin
      int cyc;
      cyc = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 150 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 99) < 70);
            2: rsp_if.ready <= ((cyc % 8) < 3);
            default: rsp_if.ready <= ($urandom_range(0, 99) < 20);
         endcase
      end
   end

   // Sends one operand word and waits until it is accepted.
   task automatic send_operand(input logic [31:0] value);
      req_if.valid      <= 1'b1;
      req_if.value_bits <= value;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // After a burst of random length, usually drops valid for a random gap.
   int burst_left;
   task automatic maybe_gap();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   endtask

   // Extremes and the special cases: zeros, infinities, NaNs, negatives.
   task automatic test_special_values();
      logic [31:0] vals[$];
      vals = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
               32'h7FC00000, 32'hFFFFFFFF, 32'h7F800001, 32'h00000001,
               32'h007FFFFF, 32'h00800000, 32'h7F7FFFFF, 32'h3F800000,
               32'h40800000, 32'h3F000000, 32'hBF800000, 32'h80000001,
               32'h5F3759DF, 32'h7FFFFFFF, 32'hC0000000, 32'h3E800000,
               32'h00000002, 32'h4B000000};
      foreach (vals[i]) send_operand(vals[i]);
   endtask

   // Random operands: mostly positive normals, plus subnormals and raw bits.
   task automatic test_random_operands(input int count);
      logic [31:0] v;
      for (int i = 0; i < count; i++) begin
         v = $urandom;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v[31:23] = {1'b0, 8'($urandom_range(1, 254))};
            5: v[30:23] = 8'($urandom_range(100, 154));
            6: v[31:23] = 9'd0;
            default: ;
         endcase
         send_operand(v);
         maybe_gap();
      end
   endtask

   initial begin
      int waited;
      error_count  = 0;
      stall_mode   = 0;
      burst_left   = 0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.value_bits = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_special_values();
      test_random_operands(1330);
      req_if.valid <= 1'b0;

      waited = 0;
      while (expected_words.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Overall time limit.
   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
